@@ rtl/tioc_pkg.sv @@
// ----------------------------------------------------------------------------
// tioc_pkg: shared types and helpers for the tensor index/offset converter
// Widths, command and status codes, register map and the 8-bit-per-stage
// shift-subtract division step used by the offset-to-index path.
// ----------------------------------------------------------------------------
package tioc_pkg;

	localparam int MAX_DIMS = 4;
	localparam int DIM_BITS = 8;
	localparam int OFF_W    = 32;
	localparam int LEN_W    = 3;
	localparam int FAIL_W   = 2;

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [OFF_W-1:0]    off_t;

	typedef enum logic [1:0] {
		CMD_TO_OFFSET = 2'd0,
		CMD_TO_INDEX  = 2'd1,
		CMD_RANGE     = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_LEN_MISMATCH  = 3'd1,
		ST_INDEX_OUT     = 3'd2,
		ST_MAX_OUT       = 3'd3,
		ST_MIN_ABOVE_MAX = 3'd4,
		ST_OFFSET_OUT    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_DIM_COUNT = 3'd0,
		REG_SIZE_0    = 3'd1,
		REG_SIZE_1    = 3'd2,
		REG_SIZE_2    = 3'd3,
		REG_SIZE_3    = 3'd4
	} reg_idx_t;

	// quotient digit and remainder of one division chunk
	typedef struct packed {
		dim_t q;
		dim_t rem;
	} div_t;

	// DIM_BITS restoring steps: shift in one dividend bit, compare, subtract
	function automatic div_t div_chunk(dim_t rem_in, dim_t bits, dim_t dvs);
		logic [DIM_BITS:0] r;
		div_t              res;
		r     = {1'b0, rem_in};
		res.q = '0;
		for (int i = DIM_BITS - 1; i >= 0; i--) begin
			r = {r[DIM_BITS-1:0], bits[i]};
			if (r >= {1'b0, dvs}) begin
				r        = r - {1'b0, dvs};
				res.q[i] = 1'b1;
			end
		end
		res.rem = r[DIM_BITS-1:0];
		return res;
	endfunction

endpackage

@@ rtl/tioc_req_if.sv @@
// ----------------------------------------------------------------------------
// tioc_req_if: command channel of the tensor index/offset converter
// valid/ready handshake carrying one conversion request per beat.
// ----------------------------------------------------------------------------
interface tioc_req_if;
	import tioc_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic [LEN_W-1:0]    index_length;
	dim_t                low_0;
	dim_t                low_1;
	dim_t                low_2;
	dim_t                low_3;
	dim_t                high_0;
	dim_t                high_1;
	dim_t                high_2;
	dim_t                high_3;
	off_t                linear_offset;

	modport source (
		output valid, command, index_length, low_0, low_1, low_2, low_3,
		output high_0, high_1, high_2, high_3, linear_offset,
		input  ready
	);

	modport sink (
		input  valid, command, index_length, low_0, low_1, low_2, low_3,
		input  high_0, high_1, high_2, high_3, linear_offset,
		output ready
	);

endinterface

@@ rtl/tioc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tioc_rsp_if: result channel of the tensor index/offset converter
// valid/ready handshake carrying one conversion result per beat.
// ----------------------------------------------------------------------------
interface tioc_rsp_if;
	import tioc_pkg::*;

	logic                valid;
	logic                ready;
	off_t                result_offset;
	dim_t                coord_0;
	dim_t                coord_1;
	dim_t                coord_2;
	dim_t                coord_3;
	logic [2:0]          status;
	logic [FAIL_W-1:0]   failing_dimension;

	modport source (
		output valid, result_offset, coord_0, coord_1, coord_2, coord_3,
		output status, failing_dimension,
		input  ready
	);

	modport sink (
		input  valid, result_offset, coord_0, coord_1, coord_2, coord_3,
		input  status, failing_dimension,
		output ready
	);

endinterface

@@ rtl/tioc_radix_split.sv @@
// ----------------------------------------------------------------------------
// tioc_radix_split: pipelined mixed-radix split of a linear offset
// Nine stages of shift-subtract division, one quotient digit per stage:
// four for size_0, three for size_1, two for size_2. The last quotient is
// the dimension 3 coordinate when the offset is in range.
// ----------------------------------------------------------------------------
module tioc_radix_split (
	input  logic           clk,
	input  logic           en,
	input  tioc_pkg::off_t offset,
	input  tioc_pkg::dim_t size_0,
	input  tioc_pkg::dim_t size_1,
	input  tioc_pkg::dim_t size_2,
	output tioc_pkg::dim_t coord_0,
	output tioc_pkg::dim_t coord_1,
	output tioc_pkg::dim_t coord_2,
	output tioc_pkg::dim_t coord_3
);
	import tioc_pkg::*;

	localparam int W0 = 4 * DIM_BITS;
	localparam int W1 = 3 * DIM_BITS;
	localparam int W2 = 2 * DIM_BITS;

	// dividend/quotient words: quotient digits shift in from the bottom
	logic [W0-1:0] num_a_s1, num_a_s2, num_a_s3, num_a_s4;
	dim_t          rem_a_s1, rem_a_s2, rem_a_s3, rem_a_s4;
	logic [W1-1:0] num_b_s5, num_b_s6, num_b_s7;
	dim_t          rem_b_s5, rem_b_s6, rem_b_s7;
	logic [W2-1:0] num_c_s8, num_c_s9;
	dim_t          rem_c_s8, rem_c_s9;
	dim_t          c0_s5, c0_s6, c0_s7, c0_s8, c0_s9;
	dim_t          c1_s8, c1_s9;

	div_t d1, d2, d3, d4, d5, d6, d7, d8, d9;

	// one digit per stage
	always_comb begin
		d1 = div_chunk('0, offset[W0-1 -: DIM_BITS], size_0);
		d2 = div_chunk(rem_a_s1, num_a_s1[W0-1 -: DIM_BITS], size_0);
		d3 = div_chunk(rem_a_s2, num_a_s2[W0-1 -: DIM_BITS], size_0);
		d4 = div_chunk(rem_a_s3, num_a_s3[W0-1 -: DIM_BITS], size_0);
		d5 = div_chunk('0, num_a_s4[W1-1 -: DIM_BITS], size_1);
		d6 = div_chunk(rem_b_s5, num_b_s5[W1-1 -: DIM_BITS], size_1);
		d7 = div_chunk(rem_b_s6, num_b_s6[W1-1 -: DIM_BITS], size_1);
		d8 = div_chunk('0, num_b_s7[W2-1 -: DIM_BITS], size_2);
		d9 = div_chunk(rem_c_s8, num_c_s8[W2-1 -: DIM_BITS], size_2);
	end

	// stage registers, advance with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			num_a_s1 <= {offset[W0-DIM_BITS-1:0], d1.q};
			rem_a_s1 <= d1.rem;
			num_a_s2 <= {num_a_s1[W0-DIM_BITS-1:0], d2.q};
			rem_a_s2 <= d2.rem;
			num_a_s3 <= {num_a_s2[W0-DIM_BITS-1:0], d3.q};
			rem_a_s3 <= d3.rem;
			num_a_s4 <= {num_a_s3[W0-DIM_BITS-1:0], d4.q};
			rem_a_s4 <= d4.rem;

			num_b_s5 <= {num_a_s4[W1-DIM_BITS-1:0], d5.q};
			rem_b_s5 <= d5.rem;
			num_b_s6 <= {num_b_s5[W1-DIM_BITS-1:0], d6.q};
			rem_b_s6 <= d6.rem;
			num_b_s7 <= {num_b_s6[W1-DIM_BITS-1:0], d7.q};
			rem_b_s7 <= d7.rem;

			num_c_s8 <= {num_b_s7[W2-DIM_BITS-1:0], d8.q};
			rem_c_s8 <= d8.rem;
			num_c_s9 <= {num_c_s8[W2-DIM_BITS-1:0], d9.q};
			rem_c_s9 <= d9.rem;

			c0_s5 <= rem_a_s4;
			c0_s6 <= c0_s5;
			c0_s7 <= c0_s6;
			c0_s8 <= c0_s7;
			c0_s9 <= c0_s8;
			c1_s8 <= rem_b_s7;
			c1_s9 <= c1_s8;
		end
	end

	assign coord_0 = c0_s9;
	assign coord_1 = c1_s9;
	assign coord_2 = rem_c_s9;
	assign coord_3 = num_c_s9[DIM_BITS-1:0];

endmodule

@@ rtl/tensor_index_offset_converter_unit.sv @@
// ----------------------------------------------------------------------------
// tensor_index_offset_converter_unit: tensor index <-> linear offset unit
// Bounds checks, index-to-offset, offset-to-index and range validation for
// a tensor of up to four dimensions, with sizes held in APB registers.
// ----------------------------------------------------------------------------
// The unit takes one request beat per clock while not stalled and returns
// results in order. The depth is set by the offset-to-index split: nine
// shift-subtract division stages of one 8-bit quotient digit each, with the
// bounds checks and the stride multiply-accumulate running alongside in the
// first four stages. A waiting result held by a low rsp.ready stalls the whole
// pipeline and req.ready drops with it. Sizes and dim_count feed every stage
// directly, so write them only while no request is in flight.
// ----------------------------------------------------------------------------
module tensor_index_offset_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tioc_req_if.sink    req,
	tioc_rsp_if.source  rsp
);
	import tioc_pkg::*;

	localparam int DEPTH = 10;

	typedef struct packed {
		logic [2:0]        status;
		logic [FAIL_W-1:0] fail;
		off_t              offset;
		logic              coord_ok;
	} meta_t;

	// configuration
	logic [LEN_W-1:0] dim_count_q;
	dim_t             size_q [MAX_DIMS];
	logic [2:0]       reg_idx;

	// pipeline control
	logic             vld_s [1:DEPTH];
	logic             adv;

	// stage 1 logic
	logic [LEN_W-1:0]  n_act;
	logic [MAX_DIMS-1:0] used, idx_bad, max_bad, ord_bad;
	dim_t              lo [MAX_DIMS];
	dim_t              hi [MAX_DIMS];
	dim_t              lo_m [MAX_DIMS];
	logic [FAIL_W-1:0] idx_fail, max_fail, ord_fail;
	logic [2:0]        chk_status;
	logic [FAIL_W-1:0] chk_fail;

	// stage registers
	logic [1:0]        cmd_s1, cmd_s2, cmd_s3;
	logic [2:0]        st_s1, st_s2, st_s3;
	logic [FAIL_W-1:0] fail_s1, fail_s2, fail_s3;
	dim_t              lo0_s1, lo2_s1, lo3_s1, lo3_s2;
	logic [15:0]       s01_s1, s01_s2, s01_s3, p1_s1;
	logic [23:0]       s012_s2, s012_s3, p2_s2;
	logic [16:0]       acc_s2;
	logic [24:0]       acc_s3;
	off_t              cnt_s3, p3_s3;
	off_t              lin_s1, lin_s2, lin_s3;
	meta_t             meta_s [4:9];
	meta_t             meta_nxt;
	off_t              cnt_sel;
	logic              oor;

	// split results and output stage
	dim_t              c0, c1, c2, c3;
	off_t              offset_s10;
	dim_t              coord_0_s10, coord_1_s10, coord_2_s10, coord_3_s10;
	logic [2:0]        status_s10;
	logic [FAIL_W-1:0] fail_s10;

	// ------------------------------------------------------------------
	// APB register file
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= '0;
			for (int d = 0; d < MAX_DIMS; d++) begin
				size_q[d] <= dim_t'(1);
			end
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_DIM_COUNT: dim_count_q <= pwdata[LEN_W-1:0];
				REG_SIZE_0:    size_q[0] <= pwdata[DIM_BITS-1:0];
				REG_SIZE_1:    size_q[1] <= pwdata[DIM_BITS-1:0];
				REG_SIZE_2:    size_q[2] <= pwdata[DIM_BITS-1:0];
				REG_SIZE_3:    size_q[3] <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DIM_COUNT: prdata = 32'(dim_count_q);
			REG_SIZE_0:    prdata = 32'(size_q[0]);
			REG_SIZE_1:    prdata = 32'(size_q[1]);
			REG_SIZE_2:    prdata = 32'(size_q[2]);
			REG_SIZE_3:    prdata = 32'(size_q[3]);
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline advance: all stages move together unless the output is held
	// ------------------------------------------------------------------
	assign adv       = !vld_s[DEPTH] || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= req.valid;
			for (int k = 2; k <= DEPTH; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: active dimensions and the index and range bounds checks
	// ------------------------------------------------------------------
	assign n_act = (dim_count_q > LEN_W'(MAX_DIMS)) ? LEN_W'(MAX_DIMS) : dim_count_q;

	assign lo[0] = req.low_0;
	assign lo[1] = req.low_1;
	assign lo[2] = req.low_2;
	assign lo[3] = req.low_3;
	assign hi[0] = req.high_0;
	assign hi[1] = req.high_1;
	assign hi[2] = req.high_2;
	assign hi[3] = req.high_3;

	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			used[d]    = LEN_W'(d) < n_act;
			lo_m[d]    = used[d] ? lo[d] : '0;
			idx_bad[d] = used[d] && (lo[d] >= size_q[d]);
			max_bad[d] = used[d] && (hi[d] > size_q[d]);
			ord_bad[d] = used[d] && (lo[d] > hi[d]);
		end
		// lowest failing dimension wins
		idx_fail = '0;
		max_fail = '0;
		ord_fail = '0;
		for (int d = MAX_DIMS - 1; d >= 0; d--) begin
			if (idx_bad[d]) idx_fail = FAIL_W'(d);
			if (max_bad[d]) max_fail = FAIL_W'(d);
			if (ord_bad[d]) ord_fail = FAIL_W'(d);
		end
	end

	always_comb begin
		chk_status = ST_OK;
		chk_fail   = '0;
		case (cmd_t'(req.command))
			CMD_TO_OFFSET, CMD_RANGE: begin
				if (req.index_length != n_act) begin
					chk_status = ST_LEN_MISMATCH;
				end else if (|idx_bad) begin
					chk_status = ST_INDEX_OUT;
					chk_fail   = idx_fail;
				end else if (cmd_t'(req.command) == CMD_RANGE) begin
					if (|max_bad) begin
						chk_status = ST_MAX_OUT;
						chk_fail   = max_fail;
					end else if (|ord_bad) begin
						chk_status = ST_MIN_ABOVE_MAX;
						chk_fail   = ord_fail;
					end
				end
			end
			default: ;
		endcase
	end

	// stage 1..3: strides and weighted coordinates, a stride multiply and a coordinate multiply per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= req.command;
			st_s1   <= chk_status;
			fail_s1 <= chk_fail;
			lo0_s1  <= lo_m[0];
			lo2_s1  <= lo_m[2];
			lo3_s1  <= lo_m[3];
			s01_s1  <= 16'(size_q[0]) * 16'(size_q[1]);
			p1_s1   <= 16'(size_q[0]) * 16'(lo_m[1]);
			lin_s1  <= req.linear_offset;

			cmd_s2  <= cmd_s1;
			st_s2   <= st_s1;
			fail_s2 <= fail_s1;
			lo3_s2  <= lo3_s1;
			s01_s2  <= s01_s1;
			s012_s2 <= 24'(s01_s1) * 24'(size_q[2]);
			p2_s2   <= 24'(s01_s1) * 24'(lo2_s1);
			acc_s2  <= 17'(lo0_s1) + 17'(p1_s1);
			lin_s2  <= lin_s1;

			cmd_s3  <= cmd_s2;
			st_s3   <= st_s2;
			fail_s3 <= fail_s2;
			s01_s3  <= s01_s2;
			s012_s3 <= s012_s2;
			cnt_s3  <= 32'(s012_s2) * 32'(size_q[3]);
			p3_s3   <= 32'(s012_s2) * 32'(lo3_s2);
			acc_s3  <= 25'(acc_s2) + 25'(p2_s2);
			lin_s3  <= lin_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: element count compare, final offset, final status
	// ------------------------------------------------------------------
	always_comb begin
		case (n_act)
			3'd1:    cnt_sel = off_t'(size_q[0]);
			3'd2:    cnt_sel = off_t'(s01_s3);
			3'd3:    cnt_sel = off_t'(s012_s3);
			3'd4:    cnt_sel = cnt_s3;
			default: cnt_sel = '0;
		endcase
		oor = (n_act == '0) || (lin_s3 >= cnt_sel);

		meta_nxt.status   = st_s3;
		meta_nxt.fail     = fail_s3;
		meta_nxt.offset   = '0;
		meta_nxt.coord_ok = 1'b0;
		case (cmd_t'(cmd_s3))
			CMD_TO_OFFSET: begin
				if (st_s3 == ST_OK) meta_nxt.offset = off_t'(acc_s3) + p3_s3;
			end
			CMD_TO_INDEX: begin
				if (oor) meta_nxt.status = ST_OFFSET_OUT;
				else     meta_nxt.coord_ok = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[4] <= meta_nxt;
			for (int k = 5; k <= 9; k++) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	// offset split into coordinates, stages 1..9
	tioc_radix_split u_split (
		.clk     (clk),
		.en      (adv),
		.offset  (req.linear_offset),
		.size_0  (size_q[0]),
		.size_1  (size_q[1]),
		.size_2  (size_q[2]),
		.coord_0 (c0),
		.coord_1 (c1),
		.coord_2 (c2),
		.coord_3 (c3)
	);

	// ------------------------------------------------------------------
	// Stage 10: output register, unused dimensions read as zero
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			offset_s10  <= meta_s[9].offset;
			status_s10  <= meta_s[9].status;
			fail_s10    <= meta_s[9].fail;
			coord_0_s10 <= (meta_s[9].coord_ok && used[0]) ? c0 : '0;
			coord_1_s10 <= (meta_s[9].coord_ok && used[1]) ? c1 : '0;
			coord_2_s10 <= (meta_s[9].coord_ok && used[2]) ? c2 : '0;
			coord_3_s10 <= (meta_s[9].coord_ok && used[3]) ? c3 : '0;
		end
	end

	assign rsp.valid             = vld_s[DEPTH];
	assign rsp.result_offset     = offset_s10;
	assign rsp.coord_0           = coord_0_s10;
	assign rsp.coord_1           = coord_1_s10;
	assign rsp.coord_2           = coord_2_s10;
	assign rsp.coord_3           = coord_3_s10;
	assign rsp.status            = status_s10;
	assign rsp.failing_dimension = fail_s10;

endmodule

@@ tb/tb_tensor_index_offset_converter_unit.sv @@
// ----------------------------------------------------------------------------
// tb_tensor_index_offset_converter_unit: self-checking bench for the converter
// A queue-fed driver offers request beats and a clocked monitor checks every
// result beat, in order, against a predictor that runs on a mirror of the
// APB registers. A short directed list covers the size and command corners.
// Random phases follow, each under its own register setting and idle mix,
// with one long result-side hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb_tensor_index_offset_converter_unit;
	import tioc_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_PHASES    = 8;
	localparam int BEATS_PER_PHASE  = 65;
	localparam int LONG_STALL       = 80;
	localparam int TAIL_CYCLES      = 16;
	localparam int MAX_REPORTS      = 100;

	typedef struct packed {
		logic [1:0]                  command;
		logic [LEN_W-1:0]            index_length;
		dim_t [MAX_DIMS-1:0]         low;
		dim_t [MAX_DIMS-1:0]         high;
		off_t                        linear_offset;
	} conv_req_t;

	typedef struct packed {
		off_t                        result_offset;
		dim_t [MAX_DIMS-1:0]         coord;
		status_t                     status;
		logic [FAIL_W-1:0]           failing_dimension;
	} conv_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tioc_req_if req_ch ();
	tioc_rsp_if rsp_ch ();

	tensor_index_offset_converter_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// register mirror used by the predictor
	logic [2:0]          cfg_dim_count;
	dim_t [MAX_DIMS-1:0] cfg_size;

	conv_req_t   pending_beats[$];
	conv_res_t   pending_results[$];

	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          req_fired;
	bit          stall_kick;
	int          stall_left;
	int          beats_in;
	int          results_checked;
	int          fail_count;
	int          cfg_changes;
	int          status_tally[8];
	int unsigned cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tensor_index_offset_converter_unit verification failed");
		$finish;
	end

	function automatic int active_dims();
		return (cfg_dim_count > MAX_DIMS) ? MAX_DIMS : int'(cfg_dim_count);
	endfunction

	function automatic logic [63:0] element_count();
		logic [63:0] prod;
		int          n;
		n    = active_dims();
		prod = 1;
		for (int d = 0; d < n; d++)
			prod = prod * cfg_size[d];
		return (n == 0) ? 64'd0 : prod;
	endfunction

	// append at the tail of the request and result queues
	task automatic add_beat(input conv_req_t b);
		pending_beats.insert(pending_beats.size(), b);
	endtask

	task automatic add_result(input conv_res_t r);
		pending_results.insert(pending_results.size(), r);
	endtask

	// expected result beat for one request under the current registers
	function automatic conv_res_t predict_conversion(conv_req_t b);
		conv_res_t   r;
		int          n;
		bit          done;
		logic [63:0] stride;
		logic [63:0] acc;
		logic [63:0] rest;
		r    = '0;
		n    = active_dims();
		done = 1'b0;
		if (b.command == CMD_TO_OFFSET || b.command == CMD_RANGE) begin
			if (b.index_length != n) begin
				r.status = ST_LEN_MISMATCH;
				done     = 1'b1;
			end
			for (int d = 0; d < n; d++) begin
				if (!done && b.low[d] >= cfg_size[d]) begin
					r.status            = ST_INDEX_OUT;
					r.failing_dimension = FAIL_W'(d);
					done                = 1'b1;
				end
			end
			if (!done && b.command == CMD_TO_OFFSET) begin
				stride = 1;
				acc    = 0;
				for (int d = 0; d < n; d++) begin
					acc    = acc + stride * b.low[d];
					stride = stride * cfg_size[d];
				end
				r.result_offset = acc[OFF_W-1:0];
			end else if (!done) begin
				// inclusive upper bound first, then ordering of the corners
				for (int d = 0; d < n; d++) begin
					if (!done && b.high[d] > cfg_size[d]) begin
						r.status            = ST_MAX_OUT;
						r.failing_dimension = FAIL_W'(d);
						done                = 1'b1;
					end
				end
				for (int d = 0; d < n; d++) begin
					if (!done && b.low[d] > b.high[d]) begin
						r.status            = ST_MIN_ABOVE_MAX;
						r.failing_dimension = FAIL_W'(d);
						done                = 1'b1;
					end
				end
			end
		end else if (b.command == CMD_TO_INDEX) begin
			rest = 64'(b.linear_offset);
			if (rest >= element_count()) begin
				r.status = ST_OFFSET_OUT;
			end else begin
				for (int d = 0; d < n; d++) begin
					r.coord[d] = dim_t'(rest % cfg_size[d]);
					rest       = rest / cfg_size[d];
				end
			end
		end
		return r;
	endfunction

	// random size: mostly small, sometimes zero or full width
	function automatic dim_t pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 8'd0;
		if (r < 16)
			return 8'd255;
		return dim_t'($urandom_range(12, 1));
	endfunction

	// mostly well-formed requests for the current setting, some noise
	function automatic conv_req_t gen_random_beat();
		conv_req_t   b;
		int          n;
		int unsigned sz;
		int          pick;
		logic [63:0] count;
		b.command      = 2'($urandom_range(3));
		b.index_length = LEN_W'($urandom_range(7));
		for (int d = 0; d < MAX_DIMS; d++) begin
			b.low[d]  = dim_t'($urandom);
			b.high[d] = dim_t'($urandom);
		end
		b.linear_offset = $urandom;
		if ($urandom_range(99) < 25)
			return b;
		n              = active_dims();
		count          = element_count();
		b.command      = 2'($urandom_range(CMD_RANGE, CMD_TO_OFFSET));
		b.index_length = LEN_W'(n);
		for (int d = 0; d < n; d++) begin
			sz        = cfg_size[d];
			b.low[d]  = (sz == 0) ? 8'd0 : dim_t'($urandom_range(sz - 1));
			b.high[d] = dim_t'($urandom_range(sz, b.low[d]));
		end
		b.linear_offset = (count == 0) ? off_t'($urandom)
			: off_t'($urandom_range(32'(count - 64'd1)));
		// now and then push one field onto or past its edge
		if ($urandom_range(99) < 15) begin
			pick = $urandom_range(MAX_DIMS - 1);
			case ($urandom_range(3))
				0: b.low[pick]  = dim_t'(cfg_size[pick] + $urandom_range(1));
				1: b.high[pick] = dim_t'(cfg_size[pick] + 1);
				2: b.high[pick] = dim_t'(b.low[pick] - 1);
				default: b.linear_offset = count[OFF_W-1:0] - $urandom_range(1);
			endcase
		end
		return b;
	endfunction

	task automatic queue_beat(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
			input dim_t l0, input dim_t l1, input dim_t l2, input dim_t l3,
			input dim_t h0, input dim_t h1, input dim_t h2, input dim_t h3,
			input off_t offset);
		conv_req_t b;
		b.command       = cmd;
		b.index_length  = len;
		b.low           = {l3, l2, l1, l0};
		b.high          = {h3, h2, h1, h0};
		b.linear_offset = offset;
		add_beat(b);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DIM_COUNT: cfg_dim_count = value[2:0];
			REG_SIZE_0:    cfg_size[0]   = value[7:0];
			REG_SIZE_1:    cfg_size[1]   = value[7:0];
			REG_SIZE_2:    cfg_size[2]   = value[7:0];
			default:       cfg_size[3]   = value[7:0];
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apply_config(input logic [2:0] dims, input dim_t s0, input dim_t s1,
			input dim_t s2, input dim_t s3);
		apb_write(REG_DIM_COUNT, {29'd0, dims});
		apb_write(REG_SIZE_0, {24'd0, s0});
		apb_write(REG_SIZE_1, {24'd0, s1});
		apb_write(REG_SIZE_2, {24'd0, s2});
		apb_write(REG_SIZE_3, {24'd0, s3});
		cfg_changes++;
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
			1: begin tx_idle_pct = 73; rx_idle_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_idle_pct = 73; end
			default: begin tx_idle_pct = 35; rx_idle_pct = 35; end
		endcase
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
	endtask

	// request driver: hold a beat until taken, then maybe idle
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_fired) begin
			// beat still waiting for ready
		end else if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
			req_ch.valid         <= 1'b1;
			req_ch.command       <= pending_beats[0].command;
			req_ch.index_length  <= pending_beats[0].index_length;
			req_ch.low_0         <= pending_beats[0].low[0];
			req_ch.low_1         <= pending_beats[0].low[1];
			req_ch.low_2         <= pending_beats[0].low[2];
			req_ch.low_3         <= pending_beats[0].low[3];
			req_ch.high_0        <= pending_beats[0].high[0];
			req_ch.high_1        <= pending_beats[0].high[1];
			req_ch.high_2        <= pending_beats[0].high[2];
			req_ch.high_3        <= pending_beats[0].high[3];
			req_ch.linear_offset <= pending_beats[0].linear_offset;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// result-side ready, with the long hold-off on top
	always @(negedge clk) begin
		if (!arst_n || stall_left > 0)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// hold-off counter
	always @(posedge clk) begin
		if (stall_kick)
			stall_left <= LONG_STALL;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	// take accepted requests into the predictor, check result beats in order
	always @(posedge clk) begin : beat_monitor
		conv_req_t taken;
		conv_res_t want;
		conv_res_t got;
		req_fired = arst_n && req_ch.valid && req_ch.ready;
		if (req_fired) begin
			taken = pending_beats.pop_front();
			want  = predict_conversion(taken);
			add_result(want);
			status_tally[want.status]++;
			beats_in++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.result_offset     = rsp_ch.result_offset;
			got.coord             = {rsp_ch.coord_3, rsp_ch.coord_2, rsp_ch.coord_1,
				rsp_ch.coord_0};
			got.status            = status_t'(rsp_ch.status);
			got.failing_dimension = rsp_ch.failing_dimension;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result beat: expected none, actual status %0d offset %h",
						$time, got.status, got.result_offset);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.result_offset !== want.result_offset) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result_offset: expected %h, actual %h",
							$time, want.result_offset, got.result_offset);
				end
				for (int d = 0; d < MAX_DIMS; d++) begin
					if (got.coord[d] !== want.coord[d]) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: coord_%0d: expected %0d, actual %0d",
								$time, d, want.coord[d], got.coord[d]);
					end
				end
				if (got.status !== want.status) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: status: expected %0d, actual %0d",
							$time, want.status, got.status);
				end
				if (got.failing_dimension !== want.failing_dimension) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: failing_dimension: expected %0d, actual %0d",
							$time, want.failing_dimension, got.failing_dimension);
				end
			end
		end
	end

	// stimulus sequence
	initial begin : stimulus
		int   base;
		logic [2:0] dims;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		req_ch.valid         = 1'b0;
		req_ch.command       = '0;
		req_ch.index_length  = '0;
		req_ch.low_0         = '0;
		req_ch.low_1         = '0;
		req_ch.low_2         = '0;
		req_ch.low_3         = '0;
		req_ch.high_0        = '0;
		req_ch.high_1        = '0;
		req_ch.high_2        = '0;
		req_ch.high_3        = '0;
		req_ch.linear_offset = '0;
		rsp_ch.ready         = 1'b0;
		stall_kick           = 1'b0;
		stall_left           = 0;
		req_fired            = 1'b0;
		beats_in             = 0;
		results_checked      = 0;
		fail_count           = 0;
		cfg_changes          = 0;
		cfg_dim_count        = 3'd0;
		cfg_size             = {MAX_DIMS{8'd1}};
		set_idle_mode(0);
		arst_n               = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset setting: no dimensions, every offset is out
		set_idle_mode(3);
		queue_beat(CMD_TO_INDEX,  3'd0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_OFFSET, 3'd0, 8'hff, 8'h55, 8'haa, 8'hff, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_RANGE,     3'd0, 8'h10, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_OFFSET, 3'd1, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		wait_drained();

		// four dimensions 3x4x5x6: every command and check
		apply_config(3'd4, 8'd3, 8'd4, 8'd5, 8'd6);
		queue_beat(CMD_TO_OFFSET, 3'd4, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_OFFSET, 3'd4, 2, 3, 4, 5, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_OFFSET, 3'd3, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_OFFSET, 3'd4, 0, 0, 5, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_INDEX,  3'd0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_INDEX,  3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 32'd359);
		queue_beat(CMD_TO_INDEX,  3'd4, 0, 0, 0, 0, 0, 0, 0, 0, 32'd360);
		queue_beat(CMD_TO_INDEX,  3'd4, 0, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff);
		queue_beat(CMD_RANGE,     3'd4, 0, 0, 0, 0, 3, 4, 5, 6, 32'd0);
		queue_beat(CMD_RANGE,     3'd4, 0, 0, 0, 0, 3, 4, 5, 7, 32'd0);
		queue_beat(CMD_RANGE,     3'd4, 0, 2, 0, 0, 1, 1, 1, 1, 32'd0);
		queue_beat(CMD_RANGE,     3'd4, 3, 0, 0, 0, 3, 4, 5, 6, 32'd0);
		queue_beat(CMD_NOP,       3'd7, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			8'hff, 32'hffffffff);
		wait_drained();

		// dim_count above the maximum clamps; full-width sizes
		apply_config(3'd7, 8'd255, 8'd255, 8'd255, 8'd255);
		queue_beat(CMD_TO_OFFSET, 3'd4, 254, 254, 254, 254, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_OFFSET, 3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_INDEX,  3'd4, 0, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff);
		queue_beat(CMD_TO_INDEX,  3'd4, 0, 0, 0, 0, 0, 0, 0, 0, 32'd4228250624);
		queue_beat(CMD_TO_OFFSET, 3'd4, 0, 0, 0, 255, 0, 0, 0, 0, 32'd0);
		wait_drained();

		// zero-sized first dimension
		apply_config(3'd2, 8'd0, 8'd10, 8'd0, 8'd0);
		queue_beat(CMD_TO_OFFSET, 3'd2, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_TO_INDEX,  3'd2, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0);
		wait_drained();

		// coordinates past dim_count are ignored
		apply_config(3'd2, 8'd7, 8'd9, 8'd0, 8'd0);
		queue_beat(CMD_TO_OFFSET, 3'd2, 6, 8, 255, 255, 0, 0, 0, 0, 32'd0);
		queue_beat(CMD_RANGE,     3'd2, 1, 2, 200, 200, 7, 9, 0, 0, 32'd0);
		wait_drained();

		// random phases, one register setting and idle mix each
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_config(3'd4, 8'd255, 8'd255, 8'd255, 8'd255);
				1: apply_config(3'd0, pick_size(), pick_size(), pick_size(), pick_size());
				2: apply_config(3'd7, pick_size(), pick_size(), pick_size(), pick_size());
				3: apply_config(3'd4, 8'd1, 8'd1, 8'd1, 8'd1);
				default: begin
					dims = ($urandom_range(99) < 70) ? 3'($urandom_range(4, 1))
						: 3'($urandom_range(7));
					apply_config(dims, pick_size(), pick_size(), pick_size(), pick_size());
				end
			endcase
			set_idle_mode(p % 4);
			base = beats_in;
			for (int i = 0; i < BEATS_PER_PHASE; i++)
				add_beat(gen_random_beat());
			if (p == 0) begin
				// long result-side hold-off while requests keep coming
				while (beats_in < base + 15)
					@(posedge clk);
				@(negedge clk);
				stall_kick = 1'b1;
				@(negedge clk);
				stall_kick = 1'b0;
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d of %0d request beats over %0d register settings, all commands.",
			results_checked, beats_in, cfg_changes + 1);
		$display("Status mix: ok %0d, length %0d, index %0d, max %0d, order %0d, offset %0d.",
			status_tally[ST_OK], status_tally[ST_LEN_MISMATCH], status_tally[ST_INDEX_OUT],
			status_tally[ST_MAX_OUT], status_tally[ST_MIN_ABOVE_MAX],
			status_tally[ST_OFFSET_OUT]);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("tensor_index_offset_converter_unit verification clean");
		else
			$display("tensor_index_offset_converter_unit verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/tioc_pkg.sv
rtl/tioc_req_if.sv
rtl/tioc_rsp_if.sv
rtl/tioc_radix_split.sv
rtl/tensor_index_offset_converter_unit.sv
tb/tb_tensor_index_offset_converter_unit.sv
